>>> rtl/mrc_pkg.sv
// Shared types, codes and the CRC-16/Modbus byte update for the Modbus RTU
// response checker. No dependencies.
package mrc_pkg;

  typedef enum logic [2:0] {
    VERDICT_GOOD       = 3'd0,
    VERDICT_TOO_SHORT  = 3'd1,
    VERDICT_WRONG_SLV  = 3'd2,
    VERDICT_EXCEPTION  = 3'd3,
    VERDICT_WRONG_FUNC = 3'd4,
    VERDICT_CRC_ERROR  = 3'd5
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  exception_code;
    logic [8:0]  frame_length;
  } result_t;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam int          MIN_FRAME     = 5;
  localparam int          HEAD_BYTES    = 3;
  localparam int          CRC_LAG       = 2;

  // one-byte update, reflected polynomial, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/modbus_rtu_response_checker.sv
// Modbus RTU response checker: top level, frame state, verdict logic,
// output register with skid stage and APB register port. Uses mrc_pkg.
//
// Takes one response byte per beat and accepts a beat every cycle while
// item_stall is low. A byte updates the count, the head bytes, the two-byte
// delay and the running CRC-16 in the cycle it is accepted; the beat that
// carries last_byte also produces the verdict, registered into the output
// register, or into the skid register while the output register holds an
// untaken verdict, and clears the frame state for the next frame. With the
// output plus skid register the byte side keeps flowing while one verdict
// waits; item_stall rises only when both hold verdicts. Bytes beyond
// MAX_FRAME are dropped, the count saturates, and frame_length reports the
// low nine bits of the count. slave_address sits at APB offset 0 and resets to 9.
module modbus_rtu_response_checker #(
  parameter int MAX_FRAME = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  // byte channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [7:0]             rx_byte,
  input  logic                   last_byte,
  input  logic [7:0]             expected_function,
  // verdict channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [2:0]             verdict,
  output logic [7:0]             exception_code,
  output logic [8:0]             frame_length,
  // APB register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import mrc_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_FRAME);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_HEAD = CW'(HEAD_BYTES);
  localparam logic [CW-1:0] CNT_LAG  = CW'(CRC_LAG);
  localparam logic [CW-1:0] CNT_MIN  = CW'(MIN_FRAME);
  localparam logic          REG_SLAVE_ADDR = 1'b0;

  // config register
  logic [7:0] slave_address;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd9;
    end else if (cfg_wr && paddr[2] == REG_SLAVE_ADDR) begin
      slave_address <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_SLAVE_ADDR) ? {24'd0, slave_address} : 32'd0;

  // frame state
  logic [15:0]   running_crc, running_crc_next;
  logic [7:0]    byte_delay [CRC_LAG];
  logic [7:0]    byte_delay_next [CRC_LAG];
  logic [CW-1:0] byte_count, byte_count_next;
  logic [7:0]    head_bytes [HEAD_BYTES];
  logic [7:0]    head_bytes_next [HEAD_BYTES];

  logic          accept;
  logic          push;
  logic [CW+8:0] count_ext;
  logic [15:0]   rx_crc;
  result_t       res_next;

  assign accept = item_valid && !item_stall;
  assign push   = accept && last_byte;

  always_comb begin
    running_crc_next = running_crc;
    byte_count_next  = byte_count;
    for (int i = 0; i < CRC_LAG; i++) begin
      byte_delay_next[i] = byte_delay[i];
    end
    for (int i = 0; i < HEAD_BYTES; i++) begin
      head_bytes_next[i] = head_bytes[i];
    end
    if (byte_count < CNT_MAX) begin
      if (byte_count < CNT_HEAD) begin
        head_bytes_next[byte_count[1:0]] = rx_byte;
      end
      if (byte_count >= CNT_LAG) begin
        running_crc_next = crc_update(running_crc, byte_delay[1]);
      end
      byte_delay_next[1] = byte_delay[0];
      byte_delay_next[0] = rx_byte;
      byte_count_next    = byte_count + CNT_ONE;
    end
  end

  // verdict from the updated frame state
  assign count_ext = {9'd0, byte_count_next};
  assign rx_crc    = {byte_delay_next[0], byte_delay_next[1]};

  always_comb begin
    res_next.exception_code = 8'd0;
    res_next.frame_length   = count_ext[8:0];
    if (byte_count_next < CNT_MIN) begin
      res_next.verdict = VERDICT_TOO_SHORT;
    end else if (head_bytes_next[0] != slave_address) begin
      res_next.verdict = VERDICT_WRONG_SLV;
    end else if (head_bytes_next[1] != expected_function) begin
      if (head_bytes_next[1] == (expected_function | EXC_FLAG)) begin
        res_next.verdict        = VERDICT_EXCEPTION;
        res_next.exception_code = head_bytes_next[2];
      end else begin
        res_next.verdict = VERDICT_WRONG_FUNC;
      end
    end else if (rx_crc != running_crc_next) begin
      res_next.verdict = VERDICT_CRC_ERROR;
    end else begin
      res_next.verdict = VERDICT_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      running_crc <= CRC_INIT;
      byte_count  <= '0;
      for (int i = 0; i < CRC_LAG; i++) begin
        byte_delay[i] <= 8'd0;
      end
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head_bytes[i] <= 8'd0;
      end
    end else if (accept) begin
      running_crc <= running_crc_next;
      byte_count  <= byte_count_next;
      for (int i = 0; i < CRC_LAG; i++) begin
        byte_delay[i] <= byte_delay_next[i];
      end
      for (int i = 0; i < HEAD_BYTES; i++) begin
        head_bytes[i] <= head_bytes_next[i];
      end
    end
  end

  // output register and skid
  result_t out_res, skid_res;
  logic    skid_valid;
  logic    pop;

  assign pop        = result_valid && !result_stall;
  assign item_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      if (!result_valid) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= res_next;
      end
    end else if (push) begin
      if (!result_valid) begin
        out_res <= res_next;
      end else begin
        skid_res <= res_next;
      end
    end
  end

  assign verdict        = out_res.verdict;
  assign exception_code = out_res.exception_code;
  assign frame_length   = out_res.frame_length;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a beat while output register is empty");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    push |=> (byte_count == '0 && running_crc == CRC_INIT))
    else $error("frame state not cleared after last byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_MAX)
    else $error("byte count beyond frame limit");

  a_exc_code_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_res.verdict != VERDICT_EXCEPTION) |-> exception_code == 8'd0)
    else $error("exception code set on a non-exception verdict");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> skid_valid && $stable(skid_res))
    else $error("skid beat lost or overwritten");
`endif

endmodule
